// ===== sv/dtq_pkg.sv =====
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 48;
    localparam int TAG_BITS    = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);

    localparam logic       OP_ENQUEUE = 1'b0;
    localparam logic       OP_FIRE    = 1'b1;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_DUE    = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic                 opcode;
        logic [TIME_BITS-1:0] now_ms;
        logic [TIME_BITS-1:0] interval_ms;
        logic [TAG_BITS-1:0]  event_tag;
    } in_req_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [TAG_BITS-1:0]  due_tag;
        logic                 arm_valid;
        logic [TIME_BITS-1:0] arm_time;
        logic                 last;
    } out_res_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_BITS-1:0]  tag;
    } ent_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        ent_t                data;
    } tbl_wr_t;

    typedef enum logic {
        ALU_ADD_SAT,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] value;
        logic                 flag;
    } alu_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CMP,
        S_INS,
        S_FCMP,
        S_FDONE
    } state_t;

endpackage

// ===== sv/dtq_alu.sv =====
`timescale 1ns / 1ps

// Shared adder/subtractor. Add saturates, flag = carry.
// Sub gives a - b, flag = borrow (a < b).
module dtq_alu
    import dtq_pkg::*;
(
    input  alu_op_t              op,
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output alu_res_t             res
);

    logic [TIME_BITS:0] sum;

    always_comb begin
        case (op)
            ALU_ADD_SAT: sum = {1'b0, a} + {1'b0, b};
            ALU_SUB:     sum = {1'b0, a} - {1'b0, b};
            default:     sum = '0;
        endcase
    end

    always_comb begin
        res.flag = sum[TIME_BITS];
        if (op == ALU_ADD_SAT && sum[TIME_BITS]) begin
            res.value = '1;
        end else begin
            res.value = sum[TIME_BITS-1:0];
        end
    end

endmodule

// ===== sv/dtq_table.sv =====
`timescale 1ns / 1ps

// Event table: one write port, one registered read port.
module dtq_table
    import dtq_pkg::*;
(
    input  logic                aclk,
    input  tbl_wr_t             wr,
    input  logic [IDX_BITS-1:0] rd_addr,
    output ent_t                rd_data
);

    ent_t mem [QUEUE_DEPTH];
    ent_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/deadline_timer_queue.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_req  (in_req_t: opcode, now, delay, tag)
// m_        out  m_valid / m_ready  m_res  (out_res_t: kind, tag, arm, last)
//
// Enqueue: S_ADD forms the deadline, S_CMP compares entries walking from the
//   tail (at most QUEUE_DEPTH - 1) on the single compare unit and table read
//   port, S_INS writes the entry and loads the result; a refusal loads in S_ADD.
// Fire: S_FCMP loads one result per due event and stops at the first event not
//   due, then S_FDONE loads the closing result. s_ready returns the cycle after.
// Reset clears count, head, armed state and the output valid; the table
//   itself needs no clearing, only written entries are ever read.
// A held result stalls only the step that wants to issue the next one;
//   s_ready rises again as soon as the sequencer is back in idle.
module deadline_timer_queue
    import dtq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output out_res_t m_res
);

    // Logical slot to physical table address, circular from head.
    function automatic logic [IDX_BITS-1:0] phys(input logic [IDX_BITS-1:0] head,
                                                 input logic [CNT_BITS-1:0] slot);
        logic [CNT_BITS:0] s;
        s = (CNT_BITS + 1)'(head) + (CNT_BITS + 1)'(slot);
        if (s >= (CNT_BITS + 1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_BITS + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_BITS-1:0];
    endfunction

    state_t               state_reg, state_next;
    in_req_t              req_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [IDX_BITS-1:0]  head_reg, head_next;
    logic [TIME_BITS-1:0] nft_reg, nft_next;
    logic                 nfv_reg, nfv_next;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0]  j_reg, j_next;
    logic [CNT_BITS-1:0]  pos_reg, pos_next;
    out_res_t             m_res_reg, res_next;
    logic                 m_valid_reg;
    logic                 load;

    logic                 s_fire;
    logic                 out_free;
    logic                 full;
    logic                 shift;
    logic                 arm;

    tbl_wr_t              tbl_wr;
    logic [IDX_BITS-1:0]  rd_addr;
    ent_t                 rd_data;

    alu_op_t              alu_op;
    logic [TIME_BITS-1:0] alu_a, alu_b;
    alu_res_t             alu_res;

    dtq_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    dtq_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;

    // Walking back from the tail: slot 0 moves only if the new deadline is
    // strictly earlier; later slots move when their deadline is equal or later.
    assign shift = (j_reg == '0) ? alu_res.flag : !alu_res.flag;
    assign arm   = (pos_reg == '0) && (!nfv_reg || alu_res.flag);

    // Operand selection for the shared unit
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = d_reg;
        alu_b  = nft_reg;
        case (state_reg)
            S_ADD: begin
                alu_op = ALU_ADD_SAT;
                alu_a  = req_reg.now_ms;
                alu_b  = req_reg.interval_ms;
            end
            S_CMP: begin
                if (j_reg == '0) begin
                    alu_a = d_reg;
                    alu_b = rd_data.deadline;
                end else begin
                    alu_a = rd_data.deadline;
                    alu_b = d_reg;
                end
            end
            S_FCMP: begin
                alu_a = req_reg.now_ms;
                alu_b = rd_data.deadline;
            end
            default: begin
                alu_a = d_reg;
                alu_b = nft_reg;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_req.opcode == OP_ENQUEUE) begin
                        state_next = S_ADD;
                    end else if (count_reg == '0) begin
                        state_next = S_FDONE;
                    end else begin
                        state_next = S_FCMP;
                    end
                end
            end
            S_ADD: begin
                if (full) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else if (count_reg == '0) begin
                    state_next = S_INS;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (!(shift && j_reg != '0)) begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FCMP: begin
                if (alu_res.flag) begin
                    state_next = S_FDONE;
                end else if (out_free && count_reg == CNT_BITS'(1)) begin
                    state_next = S_FDONE;
                end
            end
            S_FDONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        nft_next   = nft_reg;
        nfv_next   = nfv_reg;
        d_next     = d_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        res_next   = m_res_reg;
        load       = 1'b0;
        tbl_wr     = '0;
        rd_addr    = head_reg;
        case (state_reg)
            S_ADD: begin
                d_next = alu_res.value;
                if (full) begin
                    if (out_free) begin
                        load     = 1'b1;
                        res_next = '{kind: KIND_FULL, due_tag: '0, arm_valid: 1'b0,
                                     arm_time: '0, last: 1'b1};
                    end
                end else if (count_reg == '0) begin
                    pos_next = '0;
                end else begin
                    j_next  = count_reg - CNT_BITS'(1);
                    rd_addr = phys(head_reg, count_reg - CNT_BITS'(1));
                end
            end
            S_CMP: begin
                if (shift) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = phys(head_reg, j_reg + CNT_BITS'(1));
                    tbl_wr.data = rd_data;
                    if (j_reg == '0) begin
                        pos_next = '0;
                    end else begin
                        j_next  = j_reg - CNT_BITS'(1);
                        rd_addr = phys(head_reg, j_reg - CNT_BITS'(1));
                    end
                end else begin
                    pos_next = j_reg + CNT_BITS'(1);
                end
            end
            S_INS: begin
                if (out_free) begin
                    tbl_wr.en        = 1'b1;
                    tbl_wr.addr      = phys(head_reg, pos_reg);
                    tbl_wr.data      = '{deadline: d_reg, tag: req_reg.event_tag};
                    count_next       = count_reg + CNT_BITS'(1);
                    load             = 1'b1;
                    res_next         = '{kind: KIND_ACCEPT, due_tag: '0, arm_valid: 1'b0,
                                         arm_time: '0, last: 1'b1};
                    if (arm) begin
                        nft_next           = d_reg;
                        nfv_next           = 1'b1;
                        res_next.arm_valid = 1'b1;
                        res_next.arm_time  = d_reg;
                    end
                end
            end
            S_FCMP: begin
                // no borrow on now - deadline: the head is due
                if (!alu_res.flag && out_free) begin
                    load       = 1'b1;
                    res_next   = '{kind: KIND_DUE, due_tag: rd_data.tag, arm_valid: 1'b0,
                                   arm_time: '0, last: 1'b0};
                    head_next  = phys(head_reg, CNT_BITS'(1));
                    count_next = count_reg - CNT_BITS'(1);
                    rd_addr    = phys(head_reg, CNT_BITS'(1));
                end
            end
            S_FDONE: begin
                if (out_free) begin
                    load     = 1'b1;
                    res_next = '{kind: KIND_DONE, due_tag: '0, arm_valid: 1'b0,
                                 arm_time: '0, last: 1'b1};
                    if (count_reg != '0) begin
                        nft_next           = rd_data.deadline;
                        nfv_next           = 1'b1;
                        res_next.arm_valid = 1'b1;
                        res_next.arm_time  = rd_data.deadline;
                    end else begin
                        nfv_next = 1'b0;
                    end
                end
            end
            default: begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            nft_reg     <= '0;
            nfv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            nft_reg   <= nft_next;
            nfv_reg   <= nfv_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_req;
        end
        d_reg     <= d_next;
        j_reg     <= j_next;
        pos_reg   <= pos_next;
        m_res_reg <= res_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("pending count beyond table depth");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res_next.kind == KIND_FULL) |=> $stable(count_reg))
        else $error("refused request changed the table");

    a_due_needs_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res_next.kind == KIND_DUE) |-> (count_reg != '0))
        else $error("due event reported from an empty table");

    a_last_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (res_next.last == (res_next.kind != KIND_DUE)))
        else $error("last flag out of step with result kind");

    a_empty_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FDONE && out_free && count_reg == '0) |=> !nfv_reg)
        else $error("timer left armed with no events pending");

endmodule
